@@ design/lphm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_pkg: shared types and constants of the linear probe hash map
// Request opcodes, result status codes, default sizes and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lphm_pkg;

  // Default sizes for the top level parameters.
  localparam int unsigned MaxBucketsDef = 1024;
  localparam int unsigned MinBucketsDef = 8;
  localparam int unsigned KeyBitsDef    = 32;
  localparam int unsigned ValueBitsDef  = 32;

  // Request opcodes.
  localparam logic [2:0] OP_LOOKUP     = 3'd0;
  localparam logic [2:0] OP_INSERT     = 3'd1;
  localparam logic [2:0] OP_ERASE      = 3'd2;
  localparam logic [2:0] OP_LOOKUP_INS = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_EXISTS = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LATCH,
    CMD_LOAD_REQ,
    CMD_LOAD_SCR,
    CMD_PINIT,
    CMD_PROBE,
    CMD_PUT,
    CMD_PUT_REIN,
    CMD_TOMB,
    CMD_SET_GROW,
    CMD_SET_SHRINK,
    CMD_COPY0,
    CMD_COPY,
    CMD_WIPE,
    CMD_RESIZE,
    CMD_IDX_INC
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    ptr_zero;
    logic    reset_cnt;
    logic    emit;
    logic    res_we;
    logic    res_found;
    status_e res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic       req_valid;
    logic [2:0] opcode;
    logic       hash_busy;
    logic       probe_end;
    logic       hit;
    logic       tomb_v;
    logic       hole_v;
    logic       need_grow;
    logic       need_shrink;
    logic       copy_last;
    logic       wipe_last;
    logic       idx_last;
    logic       scr_live;
    logic       out_free;
  } dp_stat_t;

endpackage

@@ design/lphm_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_req_if: request channel of the hash map
// Valid/ready channel carrying opcode, key and value.
// ----------------------------------------------------------------------------
interface lphm_req_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            opcode;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, opcode, key, value, input ready);
  modport sink   (input valid, opcode, key, value, output ready);
endinterface

@@ design/lphm_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_rsp_if: result channel of the hash map
// Valid/ready channel carrying found flag, value, status and live count.
// ----------------------------------------------------------------------------
interface lphm_rsp_if #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned LIVE_BITS  = 11
);
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [VALUE_BITS-1:0] value_out;
  logic [1:0]            status;
  logic [LIVE_BITS-1:0]  live_entries;

  modport source (output valid, found, value_out, status, live_entries, input ready);
  modport sink   (input valid, found, value_out, status, live_entries, output ready);
endinterface

@@ design/linear_probe_hash_map.sv @@
`timescale 1ns / 1ps
// With a power-of-two bucket count the home slot is taken from the low key bits; a
// lookup or insert zero that misses adds a second probe. Otherwise the serial
// remainder unit computes the key modulo the bucket count for each hash. A resize
// copies the old table out, wipes the whole table and rehashes and probes each live
// entry, and a clear wipes every slot. One request is in flight, so a new request
// is taken in the cycle after the previous result is loaded, even while that result
// still waits. After reset a pass marks every slot empty and no request is accepted
// until it ends.
// ----------------------------------------------------------------------------
// linear_probe_hash_map: open addressing key-value table
// Linear probing with tombstones, automatic growth and shrink by rebuild.
// ----------------------------------------------------------------------------
module linear_probe_hash_map #(
  parameter int unsigned MAX_BUCKETS = lphm_pkg::MaxBucketsDef,
  parameter int unsigned MIN_BUCKETS = lphm_pkg::MinBucketsDef,
  parameter int unsigned KEY_BITS    = lphm_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS  = lphm_pkg::ValueBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lphm_req_if.sink   req_i,
  lphm_rsp_if.source rsp_o
);
  import lphm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lphm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lphm_dp #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .MIN_BUCKETS (MIN_BUCKETS),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );
endmodule

@@ design/lphm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lphm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ design/lphm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_dp: datapath of the hash map
// Slot table and rebuild scratch memories, probe pointer, remainder unit,
// counters, result registers and the output register.
// ----------------------------------------------------------------------------
module lphm_dp #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned MIN_BUCKETS = 8,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lphm_req_if.sink          req_i,
  lphm_rsp_if.source        rsp_o,
  input  lphm_pkg::dp_cmd_t cmd_i,
  output lphm_pkg::dp_stat_t stat_o
);
  import lphm_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_BUCKETS);
  localparam int unsigned CNT_W  = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned W2     = CNT_W + 2;
  localparam int unsigned MIN_C  = (MIN_BUCKETS > MAX_BUCKETS) ? MAX_BUCKETS : MIN_BUCKETS;
  localparam int unsigned EW     = 2 + KEY_BITS + VALUE_BITS;
  localparam int unsigned SW     = 1 + KEY_BITS + VALUE_BITS;
  localparam int unsigned HC_W   = $clog2(KEY_BITS + 1);

  // Request and probe registers.
  logic [2:0]            op_q;
  logic [KEY_BITS-1:0]   rkey_q, pkey_q, shf_q;
  logic [VALUE_BITS-1:0] rval_q, pval_q, hit_val_q, res_val_q;
  logic [ADDR_W-1:0]     ptr_q, ptr_d, idx_q, idx_d, tomb_q;
  logic [CNT_W-1:0]      steps_q, bkt_q, old_q, tgt_q, live_q, filled_q, rem_q;
  logic [HC_W-1:0]       hcnt_q;
  logic                  hbusy_q, hit_v_q, tomb_v_q, hole_v_q;
  logic                  res_found_q;
  status_e               res_status_q;
  logic                  out_valid_q, out_found_q;
  logic [VALUE_BITS-1:0] out_val_q;
  status_e               out_status_q;
  logic [CNT_W-1:0]      out_live_q;

  // Memory ports.
  logic                  t_we, s_we;
  logic [ADDR_W-1:0]     t_waddr;
  logic [EW-1:0]         t_wdata, t_rdata;
  logic [SW-1:0]         s_wdata, s_rdata;

  // Decoded slot entry; the read data always belongs to ptr_q.
  logic                  e_empty, e_tomb, key_match, pr_end;
  logic [KEY_BITS-1:0]   e_key, s_key, load_key;
  logic [VALUE_BITS-1:0] e_val, s_val;
  logic [ADDR_W-1:0]     wrap_next;
  logic                  pow2, copy_last, wipe_last, idx_last, out_free;
  logic                  need_grow, need_shrink, load;
  logic [CNT_W:0]        rem_shift, dbl;
  logic [CNT_W-1:0]      rem_next, half;
  logic [W2-1:0]         three_b;

  assign e_empty   = t_rdata[EW-1];
  assign e_tomb    = t_rdata[EW-2];
  assign e_key     = t_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign e_val     = t_rdata[VALUE_BITS-1:0];
  assign s_key     = s_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign s_val     = s_rdata[VALUE_BITS-1:0];
  assign key_match = (e_key == pkey_q);
  assign pr_end    = e_empty || (!e_tomb && key_match) || ((steps_q + 1'b1) == bkt_q);
  assign wrap_next = ((CNT_W'(ptr_q) + 1'b1) == bkt_q) ? '0 : ptr_q + 1'b1;
  assign copy_last = (CNT_W'(ptr_q) == (old_q - 1'b1));
  assign idx_last  = (CNT_W'(idx_q) == (old_q - 1'b1));
  assign wipe_last = (ptr_q == ADDR_W'(MAX_BUCKETS - 1));
  assign pow2      = ((bkt_q & (bkt_q - 1'b1)) == '0);
  assign load      = (cmd_i.op == CMD_LOAD_REQ) || (cmd_i.op == CMD_LOAD_SCR);
  assign load_key  = (cmd_i.op == CMD_LOAD_SCR) ? s_key : rkey_q;
  assign out_free  = !out_valid_q || rsp_o.ready;

  // One restoring remainder step per cycle while the hash is busy: key modulo bucket count.
  assign rem_shift = {rem_q, shf_q[KEY_BITS-1]};
  assign rem_next  = (rem_shift >= {1'b0, bkt_q}) ? CNT_W'(rem_shift - {1'b0, bkt_q})
                                                 : rem_shift[CNT_W-1:0];

  // Resize thresholds and targets.
  assign three_b     = {2'b00, bkt_q} + {1'b0, bkt_q, 1'b0};
  assign need_grow   = (({2'b00, live_q} + 1'b1) > (three_b >> 2)) &&
                       (bkt_q < CNT_W'(MAX_BUCKETS));
  assign need_shrink = ({1'b0, filled_q} > {live_q, 1'b0});
  assign dbl         = {bkt_q, 1'b0};
  assign half        = bkt_q >> 1;

  // Memory addressing and writes.
  always_comb begin
    ptr_d   = ptr_q;
    idx_d   = idx_q;
    t_we    = 1'b0;
    t_waddr = ptr_q;
    t_wdata = {2'b00, pkey_q, pval_q};
    s_we    = 1'b0;
    s_wdata = {!e_empty && !e_tomb, e_key, e_val};
    case (cmd_i.op)
      CMD_COPY0: ptr_d = '0;
      CMD_PINIT: ptr_d = rem_q[ADDR_W-1:0];
      CMD_PROBE: begin
        if (!pr_end) begin
          ptr_d = wrap_next;
        end
      end
      CMD_COPY: begin
        s_we  = 1'b1;
        ptr_d = copy_last ? '0 : ptr_q + 1'b1;
      end
      CMD_WIPE: begin
        t_we    = 1'b1;
        t_wdata = {1'b1, 1'b0, pkey_q, pval_q};
        ptr_d   = wipe_last ? '0 : ptr_q + 1'b1;
      end
      CMD_PUT, CMD_PUT_REIN: begin
        t_we    = 1'b1;
        t_waddr = tomb_v_q ? tomb_q : ptr_q;
        if (cmd_i.op == CMD_PUT_REIN) begin
          idx_d = idx_q + 1'b1;
        end
      end
      CMD_TOMB: begin
        t_we    = 1'b1;
        t_wdata = {1'b0, 1'b1, pkey_q, hit_val_q};
      end
      CMD_RESIZE:  idx_d = '0;
      CMD_IDX_INC: idx_d = idx_q + 1'b1;
      default: ;
    endcase
    if (cmd_i.ptr_zero) begin
      ptr_d = '0;
    end
  end

  lphm_ram #(.WIDTH(EW), .DEPTH(MAX_BUCKETS)) u_table (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (ptr_d),
    .rdata_o (t_rdata)
  );

  lphm_ram #(.WIDTH(SW), .DEPTH(MAX_BUCKETS)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (ptr_q),
    .wdata_i (s_wdata),
    .raddr_i (idx_d),
    .rdata_o (s_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      idx_q       <= '0;
      bkt_q       <= CNT_W'(MIN_C);
      live_q      <= '0;
      filled_q    <= '0;
      hbusy_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      idx_q <= idx_d;
      if (hbusy_q && (hcnt_q == HC_W'(1))) begin
        hbusy_q <= 1'b0;
      end
      if (load) begin
        hbusy_q <= !pow2;
      end
      case (cmd_i.op)
        CMD_PUT, CMD_PUT_REIN: begin
          live_q <= live_q + 1'b1;
          if (!tomb_v_q) begin
            filled_q <= filled_q + 1'b1;
          end
        end
        CMD_TOMB:   live_q <= live_q - 1'b1;
        CMD_RESIZE: begin
          bkt_q    <= tgt_q;
          live_q   <= '0;
          filled_q <= '0;
        end
        default: ;
      endcase
      if (cmd_i.reset_cnt) begin
        bkt_q    <= CNT_W'(MIN_C);
        live_q   <= '0;
        filled_q <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == CMD_LATCH) && req_i.valid) begin
      op_q   <= req_i.opcode;
      rkey_q <= req_i.key;
      rval_q <= req_i.value;
    end
    if (hbusy_q) begin
      rem_q  <= rem_next;
      shf_q  <= shf_q << 1;
      hcnt_q <= hcnt_q - 1'b1;
    end
    if (load) begin
      if (cmd_i.op == CMD_LOAD_SCR) begin
        pkey_q <= s_key;
        pval_q <= s_val;
      end else begin
        pkey_q <= rkey_q;
        pval_q <= (op_q == OP_LOOKUP_INS) ? '0 : rval_q;
      end
      rem_q  <= pow2 ? (CNT_W'(load_key) & (bkt_q - 1'b1)) : '0;
      shf_q  <= load_key;
      hcnt_q <= HC_W'(KEY_BITS);
    end
    case (cmd_i.op)
      CMD_PINIT: begin
        hit_v_q  <= 1'b0;
        tomb_v_q <= 1'b0;
        hole_v_q <= 1'b0;
        steps_q  <= '0;
      end
      CMD_PROBE: begin
        steps_q <= steps_q + 1'b1;
        if (e_empty) begin
          hole_v_q <= 1'b1;
        end else if (e_tomb) begin
          if (!tomb_v_q) begin
            tomb_v_q <= 1'b1;
            tomb_q   <= ptr_q;
          end
        end else if (key_match) begin
          hit_v_q   <= 1'b1;
          hit_val_q <= e_val;
        end
      end
      CMD_SET_GROW:   tgt_q <= (dbl > (CNT_W + 1)'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS)
                                                                 : dbl[CNT_W-1:0];
      CMD_SET_SHRINK: tgt_q <= (half < CNT_W'(MIN_C)) ? CNT_W'(MIN_C) : half;
      CMD_COPY0:      old_q <= bkt_q;
      default: ;
    endcase
    if (cmd_i.res_we) begin
      res_found_q  <= cmd_i.res_found;
      res_status_q <= cmd_i.res_status;
      res_val_q    <= cmd_i.res_found ? hit_val_q : '0;
    end
    if (cmd_i.emit) begin
      out_found_q  <= res_found_q;
      out_val_q    <= res_val_q;
      out_status_q <= res_status_q;
      out_live_q   <= live_q;
    end
  end

  // Ports and status.
  assign req_i.ready        = (cmd_i.op == CMD_LATCH);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.value_out    = out_val_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.live_entries = out_live_q;

  always_comb begin
    stat_o.req_valid   = req_i.valid;
    stat_o.opcode      = op_q;
    stat_o.hash_busy   = hbusy_q;
    stat_o.probe_end   = pr_end;
    stat_o.hit         = hit_v_q;
    stat_o.tomb_v      = tomb_v_q;
    stat_o.hole_v      = hole_v_q;
    stat_o.need_grow   = need_grow;
    stat_o.need_shrink = need_shrink;
    stat_o.copy_last   = copy_last;
    stat_o.wipe_last   = wipe_last;
    stat_o.idx_last    = idx_last;
    stat_o.scr_live    = s_rdata[SW-1];
    stat_o.out_free    = out_free;
  end
endmodule

@@ design/lphm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_ctrl: controller of the hash map
// Sequences probes, inserts, erases, resizes, clears and the reset wipe.
// ----------------------------------------------------------------------------
module lphm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lphm_pkg::dp_stat_t stat_i,
  output lphm_pkg::dp_cmd_t  cmd_o
);
  import lphm_pkg::*;

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_DISPATCH, S_HASH, S_PINIT, S_PROBE, S_DECIDE, S_TOMB,
    S_GROW, S_SHRINK, S_COPY0, S_COPY, S_RESIZE, S_REIN, S_INS, S_RESP
  } state_e;

  typedef enum logic [1:0] {P_REQ, P_INS, P_REIN} purpose_e;
  typedef enum logic [1:0] {W_INIT, W_CLEAR, W_REBUILD} wipe_e;

  state_e   state_q, state_d;
  purpose_e purp_q, purp_d;
  wipe_e    wmode_q, wmode_d;
  logic     ret_shrink_q, ret_shrink_d;  // rebuild returns to the shrink check
  logic     after_ins_q, after_ins_d;    // after the shrink check: insert, else respond
  state_e   ret_state;

  // Where a finished rebuild resumes.
  always_comb begin
    if (ret_shrink_q) begin
      ret_state = S_SHRINK;
    end else if (after_ins_q) begin
      ret_state = S_INS;
    end else begin
      ret_state = S_RESP;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d      = state_q;
    purp_d       = purp_q;
    wmode_d      = wmode_q;
    ret_shrink_d = ret_shrink_q;
    after_ins_d  = after_ins_q;
    cmd_o        = '{op: CMD_NOP, ptr_zero: 1'b0, reset_cnt: 1'b0, emit: 1'b0,
                     res_we: 1'b0, res_found: 1'b0, res_status: ST_DONE};
    case (state_q)
      S_WIPE: begin
        cmd_o.op = CMD_WIPE;
        if (stat_i.wipe_last) begin
          case (wmode_q)
            W_REBUILD: state_d = S_RESIZE;
            W_CLEAR: begin
              cmd_o.reset_cnt = 1'b1;
              cmd_o.res_we    = 1'b1;
              state_d         = S_RESP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_IDLE: begin
        cmd_o.op = CMD_LATCH;
        if (stat_i.req_valid) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.opcode)
          OP_LOOKUP, OP_ERASE, OP_LOOKUP_INS: begin
            cmd_o.op = CMD_LOAD_REQ;
            purp_d   = P_REQ;
            state_d  = S_HASH;
          end
          OP_INSERT: state_d = S_GROW;
          OP_CLEAR: begin
            cmd_o.ptr_zero = 1'b1;
            wmode_d        = W_CLEAR;
            state_d        = S_WIPE;
          end
          default: begin
            cmd_o.res_we = 1'b1;
            state_d      = S_RESP;
          end
        endcase
      end
      S_HASH: begin
        if (!stat_i.hash_busy) begin
          state_d = S_PINIT;
        end
      end
      S_PINIT: begin
        cmd_o.op = CMD_PINIT;
        state_d  = S_PROBE;
      end
      S_PROBE: begin
        cmd_o.op = CMD_PROBE;
        if (stat_i.probe_end) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (purp_q)
          P_REQ: begin
            cmd_o.res_we    = 1'b1;
            cmd_o.res_found = stat_i.hit;
            cmd_o.res_status = stat_i.hit ? ST_DONE : ST_ABSENT;
            state_d         = S_RESP;
            if (stat_i.opcode == OP_ERASE && stat_i.hit) begin
              state_d = S_TOMB;
            end else if (stat_i.opcode == OP_LOOKUP_INS && !stat_i.hit) begin
              cmd_o.res_we = 1'b0;
              state_d      = S_GROW;
            end
          end
          P_INS: begin
            cmd_o.res_we = 1'b1;
            state_d      = S_RESP;
            if (stat_i.hit) begin
              cmd_o.res_found  = 1'b1;
              cmd_o.res_status = (stat_i.opcode == OP_LOOKUP_INS) ? ST_DONE : ST_EXISTS;
            end else if (stat_i.tomb_v || stat_i.hole_v) begin
              cmd_o.op = CMD_PUT;
            end else begin
              cmd_o.res_status = ST_FULL;
            end
          end
          default: begin
            cmd_o.op = stat_i.hole_v ? CMD_PUT_REIN : CMD_IDX_INC;
            state_d  = stat_i.idx_last ? ret_state : S_REIN;
          end
        endcase
      end
      S_TOMB: begin
        cmd_o.op    = CMD_TOMB;
        after_ins_d = 1'b0;
        state_d     = S_SHRINK;
      end
      S_GROW: begin
        after_ins_d = 1'b1;
        if (stat_i.need_grow) begin
          cmd_o.op     = CMD_SET_GROW;
          ret_shrink_d = 1'b1;
          state_d      = S_COPY0;
        end else begin
          state_d = S_SHRINK;
        end
      end
      S_SHRINK: begin
        if (stat_i.need_shrink) begin
          cmd_o.op     = CMD_SET_SHRINK;
          ret_shrink_d = 1'b0;
          state_d      = S_COPY0;
        end else begin
          state_d = after_ins_q ? S_INS : S_RESP;
        end
      end
      S_COPY0: begin
        cmd_o.op = CMD_COPY0;
        state_d  = S_COPY;
      end
      S_COPY: begin
        cmd_o.op = CMD_COPY;
        if (stat_i.copy_last) begin
          wmode_d = W_REBUILD;
          state_d = S_WIPE;
        end
      end
      S_RESIZE: begin
        cmd_o.op = CMD_RESIZE;
        state_d  = S_REIN;
      end
      S_REIN: begin
        if (stat_i.scr_live) begin
          cmd_o.op = CMD_LOAD_SCR;
          purp_d   = P_REIN;
          state_d  = S_HASH;
        end else if (stat_i.idx_last) begin
          state_d = ret_state;
        end else begin
          cmd_o.op = CMD_IDX_INC;
        end
      end
      S_INS: begin
        cmd_o.op = CMD_LOAD_REQ;
        purp_d   = P_INS;
        state_d  = S_HASH;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_WIPE;
      purp_q       <= P_REQ;
      wmode_q      <= W_INIT;
      ret_shrink_q <= 1'b0;
      after_ins_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      purp_q       <= purp_d;
      wmode_q      <= wmode_d;
      ret_shrink_q <= ret_shrink_d;
      after_ins_q  <= after_ins_d;
    end
  end
endmodule

@@ design/lphm_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_chk: port checker of the hash map
// Checks result consistency and the result channel handshake.
// ----------------------------------------------------------------------------
module lphm_chk #(
  parameter int unsigned MAX_BUCKETS = 1024,
  parameter int unsigned VALUE_BITS  = 32,
  localparam int unsigned CNT_W      = $clog2(MAX_BUCKETS + 1)
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  rsp_valid_i,
  input logic                  rsp_ready_i,
  input logic                  found_i,
  input logic [VALUE_BITS-1:0] value_out_i,
  input logic [1:0]            status_i,
  input logic [CNT_W-1:0]      live_entries_i
);
  import lphm_pkg::*;

  // The live count never exceeds the table size.
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (live_entries_i <= CNT_W'(MAX_BUCKETS)))
    else $error("live count above table size");

  // A miss reports a zero value.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !found_i) |-> (value_out_i == '0))
    else $error("value reported for an absent key");

  // Absent and full statuses never come with a hit; skipped insert always does.
  a_status_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> ((found_i && (status_i == ST_DONE || status_i == ST_EXISTS)) ||
                     (!found_i && status_i != ST_EXISTS)))
    else $error("status disagrees with found flag");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(value_out_i) &&
                                       $stable(live_entries_i)))
    else $error("stalled result changed");
endmodule

bind linear_probe_hash_map lphm_chk #(
  .MAX_BUCKETS (MAX_BUCKETS),
  .VALUE_BITS  (VALUE_BITS)
) u_lphm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .found_i        (rsp_o.found),
  .value_out_i    (rsp_o.value_out),
  .status_i       (rsp_o.status),
  .live_entries_i (rsp_o.live_entries)
);

@@ bench/linear_probe_hash_map_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map_test: self-checking bench for the hash map
// A short directed table, which covers the done, exists and absent statuses,
// collisions, tombstones and the reserved opcodes, is followed by random request
// phases with varied idling on both channels and a fill until the table is full.
// Each result is checked field by field with its typed row or a behavioral model.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_test;
  import lphm_pkg::*;

  localparam int unsigned SLOTS      = 1024;
  localparam int unsigned MIN_SLOTS  = 8;
  localparam int unsigned WATCHDOG   = 500000;
  localparam int unsigned DRAIN_WAIT = 4000;

  // Reserved opcodes, which leave the table alone.
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct {
    bit          found;
    logic [31:0] value;
    status_e     status;
    logic [10:0] live;
  } map_rsp_t;

  typedef struct {
    logic [2:0]  opcode;
    logic [31:0] key;
    logic [31:0] value;
    bit          typed;
    map_rsp_t    rsp;
  } stim_row_t;

  typedef struct {
    int hit;
    int tomb;
    int hole;
  } slot_search_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lphm_req_if #(.KEY_BITS(32), .VALUE_BITS(32)) req_if ();
  lphm_rsp_if #(.VALUE_BITS(32), .LIVE_BITS(11)) rsp_if ();

  linear_probe_hash_map DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // Model state of the table.
  logic [31:0] slot_key [SLOTS];
  logic [31:0] slot_val [SLOTS];
  bit          slot_tomb [SLOTS];
  bit          slot_empty [SLOTS];
  int unsigned live_cnt, filled_cnt, bucket_cnt;
  logic [31:0] move_key [SLOTS];
  logic [31:0] move_val [SLOTS];
  bit          move_live [SLOTS];

  map_rsp_t    pending_rsp [$];
  int          mismatches;
  int unsigned snd_idle_pct, rcv_stall_pct;
  int unsigned hold_asks, hold_seen, hold_left;
  int unsigned quiet_cycles;

  function automatic void wipe_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_tomb[i]  = 1'b0;
      slot_empty[i] = 1'b1;
    end
    live_cnt   = 0;
    filled_cnt = 0;
    bucket_cnt = MIN_SLOTS;
  endfunction

  // Walk the probe path of a key from its home slot.
  function automatic slot_search_t search_slots(logic [31:0] key);
    slot_search_t r;
    int unsigned  s;
    r = '{-1, -1, -1};
    s = key % bucket_cnt;
    for (int i = 0; i < bucket_cnt; i++) begin
      if (slot_empty[s]) begin
        r.hole = s;
        break;
      end
      if (slot_tomb[s]) begin
        if (r.tomb < 0) r.tomb = s;
      end else if (slot_key[s] == key) begin
        r.hit = s;
        break;
      end
      s = (s + 1 == bucket_cnt) ? 0 : s + 1;
    end
    return r;
  endfunction

  function automatic void place(int unsigned s, logic [31:0] key, logic [31:0] val);
    if (slot_empty[s]) filled_cnt++;
    slot_empty[s] = 1'b0;
    slot_tomb[s]  = 1'b0;
    slot_key[s]   = key;
    slot_val[s]   = val;
    live_cnt++;
  endfunction

  // Rehash the live entries, in old slot order, into a table of a new size.
  function automatic void rehash(int unsigned new_size);
    int unsigned  old_size;
    slot_search_t r;
    old_size = bucket_cnt;
    for (int i = 0; i < old_size; i++) begin
      move_live[i] = !slot_empty[i] && !slot_tomb[i];
      move_key[i]  = slot_key[i];
      move_val[i]  = slot_val[i];
    end
    wipe_table();
    bucket_cnt = new_size;
    for (int i = 0; i < old_size; i++) begin
      if (move_live[i]) begin
        r = search_slots(move_key[i]);
        if (r.hole >= 0) place(r.hole, move_key[i], move_val[i]);
      end
    end
  endfunction

  function automatic void shrink_if_sparse();
    if (filled_cnt > 2 * live_cnt) rehash((bucket_cnt / 2 < MIN_SLOTS) ? MIN_SLOTS : bucket_cnt / 2);
  endfunction

  function automatic status_e insert_key(logic [31:0] key, logic [31:0] val,
                                         output bit found, output logic [31:0] old_val);
    slot_search_t r;
    found   = 1'b0;
    old_val = '0;
    if (live_cnt + 1 > (3 * bucket_cnt) / 4 && bucket_cnt < SLOTS) rehash(2 * bucket_cnt);
    shrink_if_sparse();
    r = search_slots(key);
    if (r.hit >= 0) begin
      found   = 1'b1;
      old_val = slot_val[r.hit];
      return ST_EXISTS;
    end
    if (r.tomb >= 0) place(r.tomb, key, val);
    else if (r.hole >= 0) place(r.hole, key, val);
    else return ST_FULL;
    return ST_DONE;
  endfunction

  // Apply one request to the model and return the result it should give.
  function automatic map_rsp_t hash_map_apply(logic [2:0] op, logic [31:0] key,
                                              logic [31:0] val);
    map_rsp_t     o;
    slot_search_t r;
    o = '{1'b0, 32'd0, ST_DONE, 11'd0};
    case (op)
      OP_LOOKUP: begin
        r = search_slots(key);
        if (r.hit >= 0) begin
          o.found = 1'b1;
          o.value = slot_val[r.hit];
        end else o.status = ST_ABSENT;
      end
      OP_INSERT: o.status = insert_key(key, val, o.found, o.value);
      OP_ERASE: begin
        r = search_slots(key);
        if (r.hit >= 0) begin
          o.found = 1'b1;
          o.value = slot_val[r.hit];
          slot_tomb[r.hit] = 1'b1;
          live_cnt--;
          shrink_if_sparse();
        end else o.status = ST_ABSENT;
      end
      OP_LOOKUP_INS: begin
        r = search_slots(key);
        if (r.hit >= 0) begin
          o.found = 1'b1;
          o.value = slot_val[r.hit];
        end else begin
          o.status = insert_key(key, 32'd0, o.found, o.value);
          if (o.status == ST_EXISTS) o.status = ST_DONE;
        end
      end
      OP_CLEAR: wipe_table();
      default: ;
    endcase
    o.live = live_cnt[10:0];
    return o;
  endfunction

  // Offer one request, wait for it to be taken and record what it must return.
  task automatic send_request(logic [2:0] op, logic [31:0] key, logic [31:0] val,
                              bit typed = 1'b0, map_rsp_t typed_rsp = '{0, 0, ST_DONE, 0});
    map_rsp_t p;
    if ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.key    <= key;
    req_if.value  <= val;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    p = hash_map_apply(op, key, val);
    pending_rsp.push_back(typed ? typed_rsp : p);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    int unsigned stride;
    case ($urandom_range(3))
      0: stride = 1;
      1: stride = 8;
      2: stride = 64;
      default: stride = 1024;
    endcase
    if ($urandom_range(99) < 15) return $urandom;
    return $urandom_range(0, 47) * stride + $urandom_range(0, 2);
  endfunction

  function automatic logic [2:0] pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return OP_INSERT;
    if (r < 55) return OP_LOOKUP;
    if (r < 80) return OP_ERASE;
    if (r < 95) return OP_LOOKUP_INS;
    if (r < 97) return OP_CLEAR;
    case ($urandom_range(2))
      0: return OP_RSVD5;
      1: return OP_RSVD6;
      default: return OP_RSVD7;
    endcase
  endfunction

  // Mixed random requests; the first phase also holds the long receiver
  // stall and a sender pause until the table has answered everything.
  task automatic mixed_phase(int n, int unsigned snd_pct, int unsigned rcv_pct,
                             bit pressure);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == 40) hold_asks++;
      if (pressure && i == 90) begin
        drain_results();
        repeat (20) @(posedge clk_i);
      end
      send_request(pick_op(), pick_key(), $urandom);
    end
  endtask

  // Receiver: random stalls plus a long hold-off when a phase asks for one.
  always @(posedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    map_rsp_t e;
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: found %0b value %h status %0d live %0d",
                                       rsp_if.found, rsp_if.value_out, rsp_if.status,
                                       rsp_if.live_entries);
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_if.found !== e.found || rsp_if.value_out !== e.value ||
            rsp_if.status !== e.status || rsp_if.live_entries !== e.live) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found %0b value %h status %0d live %0d, got %0b %h %0d %0d",
                     e.found, e.value, e.status, e.live, rsp_if.found, rsp_if.value_out,
                     rsp_if.status, rsp_if.live_entries);
        end
      end
    end
  end

  initial begin
    stim_row_t directed [$];
    map_rsp_t  done0;
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.opcode = OP_LOOKUP;
    req_if.key    = '0;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
    mismatches    = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_asks     = 0;
    hold_seen     = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    wipe_table();
    done0 = '{1'b0, 32'd0, ST_DONE, 11'd0};

    // Directed table; rows with typed results carry them, the rest use the model.
    directed = '{
      '{OP_LOOKUP,     32'h0,        32'h0,        1, '{0, 32'h0,        ST_ABSENT, 11'd0}},
      '{OP_INSERT,     32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{0, 32'h0,        ST_DONE,   11'd1}},
      '{OP_INSERT,     32'hFFFFFFFF, 32'h0,        1, '{1, 32'hFFFFFFFF, ST_EXISTS, 11'd1}},
      '{OP_LOOKUP_INS, 32'h0,        32'hFFFFFFFF, 1, '{0, 32'h0,        ST_DONE,   11'd2}},
      '{OP_LOOKUP_INS, 32'h0,        32'h1234,     1, '{1, 32'h0,        ST_DONE,   11'd2}},
      '{OP_ERASE,      32'h8,        32'h0,        1, '{0, 32'h0,        ST_ABSENT, 11'd2}},
      '{OP_LOOKUP,     32'hFFFFFFFF, 32'h0,        1, '{1, 32'hFFFFFFFF, ST_DONE,   11'd2}},
      '{OP_RSVD5,      32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{0, 32'h0,        ST_DONE,   11'd2}},
      '{OP_RSVD6,      32'h0,        32'h0,        1, '{0, 32'h0,        ST_DONE,   11'd2}},
      '{OP_RSVD7,      32'hFFFFFFFF, 32'h0,        1, '{0, 32'h0,        ST_DONE,   11'd2}},
      '{OP_CLEAR,      32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{0, 32'h0,        ST_DONE,   11'd0}},
      // Three keys sharing one home slot, then a tombstone in their run.
      '{OP_INSERT,     32'h1,        32'hA5A5A5A5, 0, done0},
      '{OP_INSERT,     32'h9,        32'h5A5A5A5A, 0, done0},
      '{OP_INSERT,     32'h11,       32'h1,        0, done0},
      '{OP_ERASE,      32'h9,        32'h0,        0, done0},
      '{OP_LOOKUP,     32'h11,       32'h0,        0, done0},
      '{OP_INSERT,     32'h11,       32'h2,        0, done0},
      '{OP_INSERT,     32'h19,       32'h3,        0, done0},
      // Erasing down to a sparse table rebuilds it at the minimum size.
      '{OP_ERASE,      32'h1,        32'h0,        0, done0},
      '{OP_ERASE,      32'h11,       32'h0,        0, done0},
      '{OP_LOOKUP_INS, 32'h19,       32'h0,        0, done0},
      '{OP_INSERT,     32'h80000000, 32'h7FFFFFFF, 0, done0},
      '{OP_ERASE,      32'hFFFFFFFF, 32'h0,        0, done0},
      '{OP_CLEAR,      32'h0,        32'h0,        1, '{0, 32'h0,        ST_DONE,   11'd0}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i])
      send_request(directed[i].opcode, directed[i].key, directed[i].value,
                   directed[i].typed, directed[i].rsp);

    // Random phases over every mix of idling.
    mixed_phase(150, 0, 0, 1'b1);
    mixed_phase(120, 49, 0, 1'b0);
    mixed_phase(120, 0, 49, 1'b0);
    mixed_phase(120, 26, 26, 1'b0);

    // Fill the table through every growth step until inserts report full.
    drain_results();
    send_request(OP_CLEAR, 32'h0, 32'h0);
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    for (int i = 0; i < 1030; i++) begin
      if (i % 2 == 0) send_request(OP_INSERT, i, $urandom);
      else send_request(OP_LOOKUP_INS, i, $urandom);
    end
    for (int i = 0; i < 12; i++)
      send_request(i % 3 == 0 ? OP_ERASE : OP_LOOKUP, $urandom_range(0, 1100), 32'h0);
    send_request(OP_CLEAR, 32'h0, 32'h0);

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
